>>> design/c8x_pkg.sv
package c8x_pkg;

  localparam int NumVregs       = 16;
  localparam int StackDepth     = 16;
  localparam int StackW         = $clog2(StackDepth);
  localparam int FontGlyphBytes = 5;
  localparam logic [11:0] ProgramStartReset = 12'd512;
  localparam logic [7:0]  RngReset = 8'h80;

  typedef enum logic [1:0] {
    CMD_EXEC = 2'd0,
    CMD_TICK = 2'd1,
    CMD_DATA = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_DONE    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_READ    = 3'd2,
    KIND_DRAW    = 3'd3,
    KIND_CLEAR   = 3'd4,
    KIND_ILLEGAL = 3'd5
  } kind_t;

  // classified operation passed from front to back
  typedef enum logic [2:0] {
    OP_SIMPLE,
    OP_CLEAR,
    OP_DRAW,
    OP_BCD,
    OP_STORE,
    OP_LOAD
  } op_class_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] opcode;
    logic [15:0] keys;
    logic [7:0]  read_data;
    op_class_t   cls;
    logic        illegal;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] next_pc;
    logic [11:0] mem_addr;
    logic [7:0]  mem_data;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  draw_rows;
    logic        sound_on;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_CLOSE
  } state_t;

  localparam logic [15:0] OpCls = 16'h00E0;
  localparam logic [15:0] OpRet = 16'h00EE;

  function automatic logic [7:0] rng_step(input logic [7:0] s);
    logic [7:0] a, r, b;
    a = (s << 4) ^ s;
    r = {a[3:0], a[7:4]};
    a = ({r[3:0], 1'b0} ^ r);
    b = (a >> 1) ^ 8'hF8;
    rng_step = a[0] ? (8'h37 ^ b) : (8'h23 ^ b);
  endfunction

endpackage

>>> design/c8x_stream_if.sv
interface c8x_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/chip8_instruction_executor_top.sv
// When the queue is empty, an accepted input beat passes through the front queue and the
// back-end's current-item register before its first result beat is registered at the output.
// The back-end sequencer takes no new item until it has emitted each result beat of the current
// one (up to 16 memory beats for Fx55/Fx65) and its closing beat; output back-pressure stalls it.
// Reset (rst, synchronous): registers cleared, pc loaded from boot_pc,
// random state 0x80; the call stack is not cleared.
module chip8_instruction_executor_top
  import c8x_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  c8x_stream_if.sink   in_ch,
  c8x_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [11:0] boot_pc;
  logic        q_valid, q_ready;
  item_t       q_item;
  result_t     res;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? {20'd0, boot_pc} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) boot_pc <= ProgramStartReset;
    else if (cfg_wr) boot_pc <= pwdata[11:0];
  end

  c8x_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .cmd(in_ch.data.cmd), .opcode(in_ch.data.opcode),
    .keys(in_ch.data.keys), .read_data(in_ch.data.read_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  c8x_back u_back (
    .clk(clk), .rst(rst), .boot_pc(boot_pc),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.data = res;

  a_last_close: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.last |-> (out_ch.data.kind == KIND_DONE ||
      out_ch.data.kind == KIND_ILLEGAL)) else $error("last on non-closing beat");
  a_mid_kind: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.data.last |-> (out_ch.data.kind != KIND_DONE &&
      out_ch.data.kind != KIND_ILLEGAL)) else $error("closing kind without last");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output beat dropped");
endmodule

>>> design/c8x_front.sv
module c8x_front
  import c8x_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [15:0] opcode,
  input  logic [15:0] keys,
  input  logic [7:0]  read_data,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);
  // two-entry queue
  item_t      mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  item_t      cls_item;
  logic       push, pop;

  always_comb begin
    cls_item = '{cmd: cmd, opcode: opcode, keys: keys, read_data: read_data,
                 cls: OP_SIMPLE, illegal: 1'b0};
    unique case (opcode[15:12])
      4'h0: begin
        if (opcode == OpCls) cls_item.cls = OP_CLEAR;
        else if (opcode != OpRet) cls_item.illegal = 1'b1;
      end
      4'h8: cls_item.illegal = !(opcode[3:0] <= 4'h7 || opcode[3:0] == 4'hE);
      4'hD: cls_item.cls = OP_DRAW;
      4'hE: cls_item.illegal = !(opcode[7:0] == 8'h9E || opcode[7:0] == 8'hA1);
      4'hF: begin
        case (opcode[7:0])
          8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29: ;
          8'h33: cls_item.cls = OP_BCD;
          8'h55: cls_item.cls = OP_STORE;
          8'h65: cls_item.cls = OP_LOAD;
          default: cls_item.illegal = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= cls_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> design/c8x_back.sv
module c8x_back
  import c8x_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [11:0] boot_pc,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);
  logic [7:0]  vreg [NumVregs];
  logic [11:0] call_stack [StackDepth];
  logic [15:0] index_reg;
  logic [11:0] pc;
  logic [StackW-1:0] stack_ptr;
  logic [7:0]  delay_timer, sound_timer, rng_state;
  logic        key_wait;
  logic [3:0]  wait_target;
  logic [4:0]  load_next, load_end;

  state_t      state, state_next;
  item_t       cur;
  logic        close_ill;
  logic [3:0]  step;
  logic [7:0]  bcd_h, bcd_t, bcd_o;
  logic [1:0]  bcd_hund;
  logic [7:0]  bcd_rem;
  logic [14:0] tens_prod;
  logic [3:0]  bcd_tens;
  logic        out_busy;

  logic [3:0]  x, y, n, lowkey;
  logic [7:0]  vx, vy, nn;
  logic [11:0] nnn, pc2;
  logic [8:0]  sum;
  logic        take, emit_now, emit_fire;
  logic [7:0]  rng_new;
  result_t     res;
  logic [3:0]  step_end;

  assign x = q_item.opcode[11:8];
  assign y = q_item.opcode[7:4];
  assign n = q_item.opcode[3:0];
  assign nn = q_item.opcode[7:0];
  assign nnn = q_item.opcode[11:0];
  assign vx = vreg[x];
  assign vy = vreg[y];
  assign pc2 = pc + 12'd2;
  assign sum = {1'b0, vx} + {1'b0, vy};
  assign rng_new = rng_step(rng_state);

  always_comb begin
    lowkey = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (q_item.keys[i]) lowkey = 4'(i);
    end
  end

  // BCD split: compare-subtract for hundreds, x*205>>11 for tens
  always_comb begin
    if (vx >= 8'd200) begin
      bcd_hund = 2'd2;
      bcd_rem = vx - 8'd200;
    end else if (vx >= 8'd100) begin
      bcd_hund = 2'd1;
      bcd_rem = vx - 8'd100;
    end else begin
      bcd_hund = 2'd0;
      bcd_rem = vx;
    end
    tens_prod = {7'd0, bcd_rem} * 15'd205;
    bcd_tens = tens_prod[14:11];
  end

  // output stage holds a beat that is not taken this cycle
  assign out_busy = out_valid && !out_ready;
  assign q_ready = (state == ST_IDLE);
  assign take = q_valid && q_ready;
  assign emit_now = (state == ST_EMIT || state == ST_CLOSE) && !out_busy;

  always_comb begin
    unique case (cur.cls)
      OP_BCD: step_end = 4'd2;
      OP_STORE, OP_LOAD: step_end = cur.opcode[11:8];
      default: step_end = 4'd0;
    endcase
  end

  always_comb begin
    res = '0;
    res.next_pc = pc;
    res.sound_on = (sound_timer != 8'd0);
    if (state == ST_CLOSE) begin
      res.kind = close_ill ? KIND_ILLEGAL : KIND_DONE;
      res.last = 1'b1;
    end else begin
      unique case (cur.cls)
        OP_CLEAR: res.kind = KIND_CLEAR;
        OP_DRAW: begin
          res.kind = KIND_DRAW;
          res.mem_addr = index_reg[11:0];
          res.draw_x = vreg[cur.opcode[11:8]];
          res.draw_y = vreg[cur.opcode[7:4]];
          res.draw_rows = cur.opcode[3:0];
        end
        OP_BCD: begin
          res.kind = KIND_WRITE;
          res.mem_addr = index_reg[11:0] + {8'd0, step};
          res.mem_data = (step == 4'd0) ? bcd_h : (step == 4'd1) ? bcd_t : bcd_o;
        end
        OP_STORE: begin
          res.kind = KIND_WRITE;
          res.mem_addr = index_reg[11:0] + {8'd0, step};
          res.mem_data = vreg[step];
        end
        OP_LOAD: begin
          res.kind = KIND_READ;
          res.mem_addr = index_reg[11:0] + {8'd0, step};
        end
        default: res.kind = KIND_DONE;
      endcase
    end
  end

  assign emit_fire = emit_now;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (q_item.cmd == CMD_EXEC && !key_wait && q_item.cls != OP_SIMPLE) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_EMIT: if (emit_now && step == step_end) state_next = ST_CLOSE;
      ST_CLOSE: if (emit_now) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_item;
      close_ill <= q_item.illegal && q_item.cmd == CMD_EXEC && !key_wait;
      bcd_h <= {6'd0, bcd_hund};
      bcd_t <= {4'd0, bcd_tens};
      bcd_o <= bcd_rem - {1'b0, bcd_tens, 3'b000} - {3'd0, bcd_tens, 1'b0};
    end
    if (take) step <= 4'd0;
    else if (emit_now && state == ST_EMIT) step <= step + 4'd1;
    if (take && q_item.cmd == CMD_EXEC && !key_wait && q_item.opcode[15:12] == 4'h2) begin
      call_stack[stack_ptr] <= pc2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumVregs; i++) vreg[i] <= 8'd0;
      index_reg <= 16'd0;
      pc <= boot_pc;
      stack_ptr <= '0;
      delay_timer <= 8'd0;
      sound_timer <= 8'd0;
      rng_state <= RngReset;
      key_wait <= 1'b0;
      wait_target <= 4'd0;
      load_next <= 5'd0;
      load_end <= 5'd0;
    end else if (take) begin
      unique case (q_item.cmd)
        CMD_TICK: begin
          if (delay_timer != 8'd0) delay_timer <= delay_timer - 8'd1;
          if (sound_timer != 8'd0) sound_timer <= sound_timer - 8'd1;
        end
        CMD_DATA: begin
          if (load_next < load_end && load_next < 5'(NumVregs)) begin
            vreg[load_next[3:0]] <= q_item.read_data;
            load_next <= load_next + 5'd1;
          end
        end
        CMD_EXEC: begin
          if (key_wait) begin
            if (q_item.keys != 16'd0) begin
              vreg[wait_target] <= {4'd0, lowkey};
              key_wait <= 1'b0;
            end
          end else begin
            pc <= pc2;
            unique case (q_item.opcode[15:12])
              4'h0: if (q_item.opcode == OpRet) begin
                pc <= call_stack[stack_ptr - 1'b1];
                stack_ptr <= stack_ptr - 1'b1;
              end
              4'h1: pc <= nnn;
              4'h2: begin
                stack_ptr <= stack_ptr + 1'b1;
                pc <= nnn;
              end
              4'h3: if (vx == nn) pc <= pc + 12'd4;
              4'h4: if (vx != nn) pc <= pc + 12'd4;
              4'h5: if (vx == vy) pc <= pc + 12'd4;
              4'h6: vreg[x] <= nn;
              4'h7: vreg[x] <= vx + nn;
              4'h8: begin
                case (n)
                  4'h0: vreg[x] <= vy;
                  4'h1: vreg[x] <= vx | vy;
                  4'h2: vreg[x] <= vx & vy;
                  4'h3: vreg[x] <= vx ^ vy;
                  4'h4: begin
                    vreg[x] <= sum[7:0];
                    vreg[15] <= {7'd0, sum[8]};
                  end
                  4'h5: begin
                    vreg[x] <= vx - vy;
                    vreg[15] <= {7'd0, vx >= vy};
                  end
                  4'h6: begin
                    vreg[x] <= vx >> 1;
                    vreg[15] <= {7'd0, vx[0]};
                  end
                  4'h7: begin
                    vreg[x] <= vy - vx;
                    vreg[15] <= {7'd0, vy >= vx};
                  end
                  4'hE: begin
                    vreg[x] <= vx << 1;
                    vreg[15] <= {7'd0, vx[7]};
                  end
                  default: ;
                endcase
              end
              4'h9: if (vx != vy) pc <= pc + 12'd4;
              4'hA: index_reg <= {4'd0, nnn};
              4'hB: pc <= {4'd0, vreg[0]} + nnn;
              4'hC: begin
                rng_state <= rng_new;
                vreg[x] <= rng_new & nn;
              end
              4'hE: begin
                if (nn == 8'h9E && q_item.keys[vx[3:0]]) pc <= pc + 12'd4;
                if (nn == 8'hA1 && !q_item.keys[vx[3:0]]) pc <= pc + 12'd4;
              end
              4'hF: begin
                case (nn)
                  8'h07: vreg[x] <= delay_timer;
                  8'h0A: begin
                    key_wait <= 1'b1;
                    wait_target <= x;
                  end
                  8'h15: delay_timer <= vx;
                  8'h18: sound_timer <= vx;
                  8'h1E: index_reg <= index_reg + {8'd0, vx};
                  8'h29: index_reg <= 16'(FontGlyphBytes * vx);
                  8'h65: begin
                    load_next <= 5'd0;
                    load_end <= {1'b0, x} + 5'd1;
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end
endmodule
